// ----- src/assert_macros.svh -----
// Assertion shorthands for the single-cycle core.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SMC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smc assertion failed");

// Next-cycle implication.
`define SMC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smc assertion failed");

`endif

// ----- src/smc_pkg.sv -----
// Shared types and constants of the single-cycle core.
// No dependencies; used by the RTL modules in src and by the testbench.
package smc_pkg;

	localparam int unsigned IMEM_WORDS_DEF = 1024;
	localparam int unsigned DMEM_WORDS_DEF = 1024;
	localparam int unsigned REG_COUNT      = 32;
	localparam int unsigned WIDX_W         = 30;	// byte address bits above bit 1

	localparam logic [1:0] FUNC_EXEC     = 2'd0;
	localparam logic [1:0] FUNC_IMEM_WR  = 2'd1;
	localparam logic [1:0] FUNC_DMEM_WR  = 2'd2;

	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2b;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2a;

	localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_WAIT,
		ST_IDX_WAIT,
		ST_FETCH,
		ST_DECODE,
		ST_EXECUTE,
		ST_DADDR,
		ST_DADDR_WAIT,
		ST_MEMORY,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic fetch;
		logic decode;
		logic execute;
		logic resolve;	// start data index, settle next pc
		logic memory;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_exec;
		logic clear_last;
		logic imod_done;
		logic dmod_done;
		logic out_free;
	} status_t;

endpackage

// ----- src/smc_if.sv -----
// Valid/ready channels of the core: request items in, result items out.
// No dependencies.
interface smc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] addr;
	logic [31:0] data;

	modport source (output valid, func, addr, data, input ready);
	modport sink   (input valid, func, addr, data, output ready);
endinterface

interface smc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pc_after;
	logic [31:0] instr_done;
	logic        reg_we;
	logic [4:0]  reg_waddr;
	logic [31:0] reg_wdata;
	logic        mem_we;
	logic [31:0] mem_addr;
	logic [31:0] mem_wdata;
	logic        redirect;

	modport source (output valid, pc_after, instr_done, reg_we, reg_waddr, reg_wdata,
		mem_we, mem_addr, mem_wdata, redirect, input ready);
	modport sink   (input valid, pc_after, instr_done, reg_we, reg_waddr, reg_wdata,
		mem_we, mem_addr, mem_wdata, redirect, output ready);
endinterface

// ----- src/smc_word_index.sv -----
// Word index unit: (byte address >> 2) modulo DEPTH.
// Power-of-two depths take a mask; others use a registered reciprocal multiply.
// Depends on smc_pkg.
module smc_word_index #(
	parameter int unsigned DEPTH = smc_pkg::IMEM_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smc_pkg::WIDX_W-1:0]    value,
	output logic                          done,
	output logic [$clog2(DEPTH)-1:0]      index
);
	import smc_pkg::*;

	localparam int unsigned AW     = $clog2(DEPTH);
	localparam bit          POW2   = ((1 << AW) == DEPTH);

	if (POW2) begin : g_mask
		logic [AW-1:0] idx_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				idx_q <= '0;
			end else if (start) begin
				idx_q <= value[AW-1:0];
			end
		end

		assign done  = 1'b1;
		assign index = idx_q;
	end else begin : g_recip
		// x - floor(x * RECIP / 2^SH) * DEPTH; the quotient estimate is at most
		// one low, so a final compare and subtract settles the remainder
		localparam int unsigned       SH      = WIDX_W + AW;
		localparam int unsigned       PW      = 2 * WIDX_W + 1;
		localparam longint unsigned   RECIP_L = (64'd1 << SH) / 64'(DEPTH);
		localparam logic [WIDX_W:0]   RECIP   = (WIDX_W+1)'(RECIP_L);
		localparam logic [WIDX_W-1:0] DEPTH_W = WIDX_W'(DEPTH);
		localparam logic [AW:0]       DEPTH_V = (AW+1)'(DEPTH);

		logic [1:0]        phase_q;
		logic [WIDX_W-1:0] x_q;
		logic [PW-SH-1:0]  quo_q;
		logic [AW:0]       rem_q;
		logic [AW-1:0]     idx_q;
		logic [PW-1:0]     prod;
		logic [WIDX_W-1:0] qd;
		logic [WIDX_W-1:0] diff;

		assign prod = PW'(x_q) * PW'(RECIP);
		assign qd   = WIDX_W'(quo_q) * DEPTH_W;
		assign diff = x_q - qd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q <= '0;
				idx_q   <= '0;
			end else if (start) begin
				phase_q <= 2'd3;
			end else if (phase_q != 2'd0) begin
				phase_q <= phase_q - 2'd1;
				if (phase_q == 2'd1) begin
					idx_q <= (rem_q >= DEPTH_V) ? AW'(rem_q - DEPTH_V) : rem_q[AW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				x_q <= value;
			end
			if (phase_q == 2'd3) begin
				quo_q <= prod[PW-1:SH];
			end
			if (phase_q == 2'd2) begin
				rem_q <= diff[AW:0];
			end
		end

		assign done  = (phase_q == 2'd0);
		assign index = idx_q;
	end

endmodule

// ----- src/smc_ctrl.sv -----
// Sequencer of the core: clearing pass, load items, instruction steps.
// Depends on smc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smc_pkg::status_t sts,
	output smc_pkg::cmd_t    cmd
);
	import smc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = sts.in_exec ? ST_IDX_WAIT : ST_LOAD_WAIT;
			end
			ST_LOAD_WAIT: begin
				if (sts.imod_done && sts.dmod_done) state_d = ST_COMMIT;
			end
			ST_IDX_WAIT: begin
				if (sts.imod_done) state_d = ST_FETCH;
			end
			ST_FETCH:   state_d = ST_DECODE;
			ST_DECODE:  state_d = ST_EXECUTE;
			ST_EXECUTE: state_d = ST_DADDR;
			ST_DADDR:   state_d = ST_DADDR_WAIT;
			ST_DADDR_WAIT: begin
				if (sts.dmod_done) state_d = ST_MEMORY;
			end
			ST_MEMORY: state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR:   cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_FETCH:   cmd.fetch   = 1'b1;
			ST_DECODE:  cmd.decode  = 1'b1;
			ST_EXECUTE: cmd.execute = 1'b1;
			ST_DADDR:   cmd.resolve = 1'b1;
			ST_MEMORY:  cmd.memory  = 1'b1;
			ST_COMMIT:  cmd.commit  = sts.out_free;
			default: ;
		endcase
	end

	`SMC_ASSERT_NEXT(a_one_item_at_a_time, cmd.accept, !in_ready)
	`SMC_ASSERT_IMPL(a_fetch_index_ready, cmd.fetch, sts.imod_done)
	`SMC_ASSERT_IMPL(a_data_index_ready, cmd.memory, sts.dmod_done)
	`SMC_ASSERT_IMPL(a_clear_ran_full, $fell(state_q == ST_CLEAR), $past(sts.clear_last))

endmodule

// ----- src/smc_datapath.sv -----
// Datapath of the core: pc, register file, both memories, ALU, result register.
// Depends on smc_pkg, smc_if and smc_word_index.
module smc_datapath #(
	parameter int unsigned IMEM_WORDS = smc_pkg::IMEM_WORDS_DEF,
	parameter int unsigned DMEM_WORDS = smc_pkg::DMEM_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  smc_pkg::cmd_t    cmd,
	output smc_pkg::status_t sts,
	smc_in_if.sink           req,
	smc_out_if.source        rsp
);
	import smc_pkg::*;

	localparam int unsigned IAW       = $clog2(IMEM_WORDS);
	localparam int unsigned DAW       = $clog2(DMEM_WORDS);
	localparam int unsigned RAW       = $clog2(REG_COUNT);
	localparam int unsigned CLR_A     = (IMEM_WORDS > DMEM_WORDS) ? IMEM_WORDS : DMEM_WORDS;
	localparam int unsigned CLR_WORDS = (CLR_A > REG_COUNT) ? CLR_A : REG_COUNT;
	localparam int unsigned CAW       = $clog2(CLR_WORDS);

	logic [31:0] imem [IMEM_WORDS];
	logic [31:0] dmem [DMEM_WORDS];
	logic [31:0] rf   [REG_COUNT];

	logic [CAW-1:0] clr_idx_q;
	logic [31:0]    pc_q;
	logic           out_valid_q;

	logic [1:0]  func_q;
	logic [31:0] data_q;
	logic [31:0] ir_q, a_q, b_q, alu_q, seq_q, next_pc_q, rdata_q;
	logic        redir_q;

	logic [31:0] pc_after_q, instr_done_q, reg_wdata_q, mem_addr_q, mem_wdata_q;
	logic [4:0]  reg_waddr_q;
	logic        reg_we_q, mem_we_q, redirect_q;

	// index units
	logic           imod_done, dmod_done;
	logic [IAW-1:0] iidx;
	logic [DAW-1:0] didx;
	logic           in_exec;

	assign in_exec = (req.func == FUNC_EXEC);

	smc_word_index #(.DEPTH(IMEM_WORDS)) u_iidx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.value  (in_exec ? pc_q[31:2] : req.addr[31:2]),
		.done   (imod_done),
		.index  (iidx)
	);

	smc_word_index #(.DEPTH(DMEM_WORDS)) u_didx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept || cmd.resolve),
		.value  (cmd.resolve ? alu_q[31:2] : req.addr[31:2]),
		.done   (dmod_done),
		.index  (didx)
	);

	// instruction fields
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd;
	logic [31:0] imm;
	logic [25:0] target;
	logic        is_lw, is_sw, is_rtype, is_exec_q;

	assign op        = ir_q[31:26];
	assign fn        = ir_q[5:0];
	assign rs        = ir_q[25:21];
	assign rt        = ir_q[20:16];
	assign rd        = ir_q[15:11];
	assign imm       = {{16{ir_q[15]}}, ir_q[15:0]};
	assign target    = ir_q[25:0];
	assign is_lw     = (op == OPC_LW);
	assign is_sw     = (op == OPC_SW);
	assign is_rtype  = (op == OPC_RTYPE);
	assign is_exec_q = (func_q == FUNC_EXEC);

	logic [31:0] alu_d;

	always_comb begin
		case (op)
			OPC_LW, OPC_SW: alu_d = a_q + imm;
			OPC_BEQ:        alu_d = a_q - b_q;
			OPC_RTYPE: begin
				case (fn)
					FN_ADD:  alu_d = a_q + b_q;
					FN_SUB:  alu_d = a_q - b_q;
					FN_AND:  alu_d = a_q & b_q;
					FN_OR:   alu_d = a_q | b_q;
					FN_SLT:  alu_d = {31'd0, (a_q < b_q)};
					default: alu_d = '0;
				endcase
			end
			default: alu_d = a_q + b_q;
		endcase
	end

	logic        beq_taken, is_jump;
	logic [31:0] next_pc_d;

	assign beq_taken = (op == OPC_BEQ) && (alu_q == '0);
	assign is_jump   = (op == OPC_J);

	always_comb begin
		if (is_jump) begin
			next_pc_d = (seq_q & JUMP_REGION_MASK) | {4'd0, target, 2'b00};
		end else if (beq_taken) begin
			next_pc_d = seq_q + {imm[29:0], 2'b00};
		end else begin
			next_pc_d = seq_q;
		end
	end

	// register write of the executed instruction
	logic        rf_we_ins;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;

	assign rf_we_ins = is_lw || is_rtype;
	assign rf_waddr  = is_lw ? rt : (is_rtype ? rd : 5'd0);
	assign rf_wdata  = is_lw ? rdata_q : (is_rtype ? alu_q : 32'd0);

	// clearing pass reach per memory
	logic clr_in_imem, clr_in_dmem, clr_in_rf;

	assign clr_in_imem = 32'(clr_idx_q) < IMEM_WORDS;
	assign clr_in_dmem = 32'(clr_idx_q) < DMEM_WORDS;
	assign clr_in_rf   = 32'(clr_idx_q) < REG_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_idx_q <= clr_idx_q + CAW'(1);
			end
			if (cmd.commit && is_exec_q) begin
				pc_q <= next_pc_q;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= req.func;
			data_q <= req.data;
		end
		if (cmd.execute) begin
			alu_q <= alu_d;
			seq_q <= pc_q + 32'd4;
		end
		if (cmd.resolve) begin
			next_pc_q <= next_pc_d;
			redir_q   <= beq_taken || is_jump;
		end
		if (cmd.commit) begin
			if (is_exec_q) begin
				pc_after_q   <= next_pc_q;
				instr_done_q <= ir_q;
				reg_we_q     <= rf_we_ins;
				reg_waddr_q  <= rf_waddr;
				reg_wdata_q  <= rf_wdata;
				mem_we_q     <= is_sw;
				mem_addr_q   <= (is_lw || is_sw) ? alu_q : 32'd0;
				mem_wdata_q  <= is_sw ? b_q : 32'd0;
				redirect_q   <= redir_q;
			end else begin
				pc_after_q   <= pc_q;
				instr_done_q <= '0;
				reg_we_q     <= 1'b0;
				reg_waddr_q  <= '0;
				reg_wdata_q  <= '0;
				mem_we_q     <= 1'b0;
				mem_addr_q   <= '0;
				mem_wdata_q  <= '0;
				redirect_q   <= 1'b0;
			end
		end
	end

	// instruction memory
	logic           imem_we;
	logic [IAW-1:0] imem_widx;

	assign imem_we   = (cmd.clear_step && clr_in_imem)
		|| (cmd.commit && func_q == FUNC_IMEM_WR);
	assign imem_widx = cmd.clear_step ? clr_idx_q[IAW-1:0] : iidx;

	always_ff @(posedge clk) begin
		if (imem_we) begin
			imem[imem_widx] <= cmd.clear_step ? 32'd0 : data_q;
		end
		if (cmd.fetch) begin
			ir_q <= imem[iidx];
		end
	end

	// data memory
	logic           dmem_we;
	logic [DAW-1:0] dmem_widx;
	logic [31:0]    dmem_wdata;

	assign dmem_we    = (cmd.clear_step && clr_in_dmem) || (cmd.memory && is_sw)
		|| (cmd.commit && func_q == FUNC_DMEM_WR);
	assign dmem_widx  = cmd.clear_step ? clr_idx_q[DAW-1:0] : didx;
	assign dmem_wdata = cmd.clear_step ? 32'd0 : (cmd.memory ? b_q : data_q);

	always_ff @(posedge clk) begin
		if (dmem_we) begin
			dmem[dmem_widx] <= dmem_wdata;
		end
		if (cmd.memory) begin
			rdata_q <= dmem[didx];
		end
	end

	// register file; entry 0 is cleared and never written afterwards
	logic           rf_we;
	logic [RAW-1:0] rf_widx;

	assign rf_we   = (cmd.clear_step && clr_in_rf)
		|| (cmd.commit && is_exec_q && rf_we_ins && rf_waddr != 5'd0);
	assign rf_widx = cmd.clear_step ? clr_idx_q[RAW-1:0] : rf_waddr;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_widx] <= cmd.clear_step ? 32'd0 : rf_wdata;
		end
		if (cmd.decode) begin
			a_q <= rf[rs];
			b_q <= rf[rt];
		end
	end

	assign sts.in_exec    = in_exec;
	assign sts.clear_last = (clr_idx_q == CAW'(CLR_WORDS - 1));
	assign sts.imod_done  = imod_done;
	assign sts.dmod_done  = dmod_done;
	assign sts.out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.pc_after   = pc_after_q;
	assign rsp.instr_done = instr_done_q;
	assign rsp.reg_we     = reg_we_q;
	assign rsp.reg_waddr  = reg_waddr_q;
	assign rsp.reg_wdata  = reg_wdata_q;
	assign rsp.mem_we     = mem_we_q;
	assign rsp.mem_addr   = mem_addr_q;
	assign rsp.mem_wdata  = mem_wdata_q;
	assign rsp.redirect   = redirect_q;

endmodule

// ----- src/single_cycle_mips_subset_core.sv -----
// MIPS subset core (lw, sw, beq, j, add, sub, and, or, unsigned slt). An item on
// req either writes one word into instruction or data memory (func 1 or 2) or
// runs the instruction at pc (func 0); each item gives exactly one result on rsp.
// After reset a clearing pass zeroes both memories and the register file, one
// word per cycle at indices 0 to max(IMEM_WORDS, DMEM_WORDS, 32) - 1; req.ready
// stays low meanwhile. The sequencer takes one item at a time: with power-of-two
// memory depths an instruction steps through index, fetch, register read, ALU,
// next pc with data index, memory and commit, and a load item through index and
// commit. Other depths lengthen each index wait (two per instruction, one per load
// item), where a reciprocal multiply computes the remainder. A finished result
// waits in the output register, so the next item is taken while it is pending.
module single_cycle_mips_subset_core #(
	parameter int unsigned IMEM_WORDS = smc_pkg::IMEM_WORDS_DEF,
	parameter int unsigned DMEM_WORDS = smc_pkg::DMEM_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	smc_in_if.sink    req,
	smc_out_if.source rsp
);
	import smc_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_ready;

	smc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smc_datapath #(
		.IMEM_WORDS (IMEM_WORDS),
		.DMEM_WORDS (DMEM_WORDS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	assign req.ready = in_ready;

endmodule

// ----- tb/tb_single_cycle_mips_subset_core.sv -----
// Self-checking testbench for single_cycle_mips_subset_core: a shadow core predicts every result
// item, a queue-fed driver and a randomly stalling monitor exercise both valid/ready channels.
// Depends on smc_pkg and the smc_in_if / smc_out_if interfaces.
module tb_single_cycle_mips_subset_core;
	timeunit 1ns;
	timeprecision 1ps;

	import smc_pkg::*;

	localparam int unsigned IMEM_N        = IMEM_WORDS_DEF;
	localparam int unsigned DMEM_N        = DMEM_WORDS_DEF;
	localparam bit [31:0]   IMEM_IDX_MASK = (IMEM_N - 1) << 2;
	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam int unsigned N_ITEMS       = 2000;
	localparam int unsigned PAUSE_AT      = 1200;
	localparam int unsigned HOLD_AT       = 700;
	localparam int unsigned HOLD_LEN      = 400;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned TAIL_CYCLES   = 50;
	localparam bit [5:0]    RFN [5]       = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};

	typedef struct packed {
		bit [31:0] pc_after;
		bit [31:0] instr_done;
		bit        reg_we;
		bit [4:0]  reg_waddr;
		bit [31:0] reg_wdata;
		bit        mem_we;
		bit [31:0] mem_addr;
		bit [31:0] mem_wdata;
		bit        redirect;
	} core_rsp_t;

	typedef struct {
		bit [1:0]    func;
		bit [31:0]   addr;
		bit [31:0]   data;
		core_rsp_t   want;
		int unsigned gap;
		bit          drain;
	} core_req_t;

	logic clk;
	logic arst_n;

	smc_in_if  req_ch ();
	smc_out_if rsp_ch ();

	single_cycle_mips_subset_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow machine state
	bit [31:0] pc_m;
	bit [31:0] regs_m [32];
	bit [31:0] imem_m [IMEM_N];
	bit [31:0] dmem_m [DMEM_N];

	core_req_t   pend_q [$];
	core_rsp_t   resp_due_q [$];
	int unsigned errors;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned tx_mode;
	bit          hold_tx;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [31:0] rd_reg(bit [4:0] idx);
		return (idx == 5'd0) ? 32'd0 : regs_m[idx];
	endfunction

	function automatic bit [31:0] sext16(bit [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Advances the shadow core by one item and returns the result item it should give.
	function automatic core_rsp_t step_core(bit [1:0] func, bit [31:0] addr, bit [31:0] data);
		core_rsp_t r;
		bit [31:0] ins, a, b, imm, seq, alu;
		bit [5:0]  op, fn;
		bit [4:0]  rs, rt, rd;
		r = '0;
		if (func != FUNC_EXEC) begin
			if (func == FUNC_IMEM_WR)
				imem_m[(addr >> 2) % IMEM_N] = data;
			else if (func == FUNC_DMEM_WR)
				dmem_m[(addr >> 2) % DMEM_N] = data;
			r.pc_after = pc_m;
			return r;
		end
		ins = imem_m[(pc_m >> 2) % IMEM_N];
		op  = ins[31:26];
		rs  = ins[25:21];
		rt  = ins[20:16];
		rd  = ins[15:11];
		fn  = ins[5:0];
		imm = sext16(ins[15:0]);
		a   = rd_reg(rs);
		b   = rd_reg(rt);
		seq = pc_m + 32'd4;
		r.pc_after   = seq;
		r.instr_done = ins;
		if (op == OPC_LW || op == OPC_SW)
			alu = a + imm;
		else if (op == OPC_BEQ)
			alu = a - b;
		else if (op == OPC_RTYPE) begin
			case (fn)
				FN_ADD:  alu = a + b;
				FN_SUB:  alu = a - b;
				FN_AND:  alu = a & b;
				FN_OR:   alu = a | b;
				FN_SLT:  alu = (a < b) ? 32'd1 : 32'd0;	// unsigned compare
				default: alu = 32'd0;
			endcase
		end else
			alu = a + b;
		case (op)
			OPC_LW: begin
				r.reg_we    = 1'b1;
				r.reg_waddr = rt;
				r.reg_wdata = dmem_m[(alu >> 2) % DMEM_N];
				r.mem_addr  = alu;
			end
			OPC_SW: begin
				r.mem_we    = 1'b1;
				r.mem_addr  = alu;
				r.mem_wdata = b;
				dmem_m[(alu >> 2) % DMEM_N] = b;
			end
			OPC_RTYPE: begin
				r.reg_we    = 1'b1;
				r.reg_waddr = rd;
				r.reg_wdata = alu;
			end
			OPC_BEQ: begin
				if (alu == 32'd0) begin
					r.pc_after = seq + (imm << 2);
					r.redirect = 1'b1;
				end
			end
			OPC_J: begin
				r.pc_after = (seq & JUMP_REGION_MASK) | {ins[25:0], 2'b00};
				r.redirect = 1'b1;
			end
			default: ;
		endcase
		if (r.reg_we && r.reg_waddr != 5'd0)
			regs_m[r.reg_waddr] = r.reg_wdata;
		pc_m = r.pc_after;
		return r;
	endfunction

	// 90% short bursts of 1..3, the rest long ones
	function automatic int unsigned pick_len();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_item(bit [1:0] func, bit [31:0] addr, bit [31:0] data);
		core_req_t p;
		if (n_items % 150 == 0)
			tx_mode = $urandom_range(0, 2);
		p.func  = func;
		p.addr  = addr;
		p.data  = data;
		p.want  = step_core(func, addr, data);
		p.gap   = (tx_mode == 0 || $urandom_range(0, 1) == 0) ? 0 : pick_len();
		p.drain = hold_tx;
		hold_tx = 1'b0;
		pend_q.push_back(p);
		n_items++;
	endtask

	// store an instruction at the current pc (through addr) and run it
	task automatic run_at(bit [31:0] ins, bit [31:0] addr);
		add_item(FUNC_IMEM_WR, addr, ins);
		add_item(FUNC_EXEC, $urandom(), $urandom());
	endtask

	function automatic bit [31:0] enc_r(bit [4:0] rs, bit [4:0] rt, bit [4:0] rd, bit [5:0] fn);
		return {OPC_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic bit [31:0] enc_i(bit [5:0] op, bit [4:0] rs, bit [4:0] rt, bit [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic bit [31:0] rand_instr();
		bit [31:0] ins;
		ins = $urandom();
		case ($urandom_range(0, 9))
			0, 1: ins[31:26] = OPC_LW;
			2, 3: ins[31:26] = OPC_SW;
			4: begin
				ins[31:26] = OPC_BEQ;
				if ($urandom_range(0, 1) != 0)
					ins[20:16] = ins[25:21];
			end
			5: ins[31:26] = OPC_J;
			6, 7, 8: begin
				ins[31:26] = OPC_RTYPE;
				if ($urandom_range(0, 4) != 0)
					ins[5:0] = RFN[$urandom_range(0, 4)];
			end
			default: ;	// random opcode, mostly unknown
		endcase
		return ins;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drv
		core_req_t nxt;
		int unsigned wait_cnt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.func  <= FUNC_EXEC;
			req_ch.addr  <= 32'd0;
			req_ch.data  <= 32'd0;
			wait_cnt = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				resp_due_q.push_back(nxt.want);
			if (!req_ch.valid || req_ch.ready) begin
				if (pend_q.size() != 0 && wait_cnt < pend_q[0].gap) begin
					wait_cnt++;
					req_ch.valid <= 1'b0;
				end else if (pend_q.size() != 0 &&
						!(pend_q[0].drain && resp_due_q.size() != 0)) begin
					nxt = pend_q.pop_front();
					wait_cnt = 0;
					req_ch.valid <= 1'b1;
					req_ch.func  <= nxt.func;
					req_ch.addr  <= nxt.addr;
					req_ch.data  <= nxt.data;
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string nm, logic [31:0] got, bit [31:0] want);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, nm, want, got);
		end
	endtask

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin : mon
		core_rsp_t   e;
		int unsigned stall_cnt;
		int unsigned hold_cnt;
		int unsigned mode_cnt;
		int unsigned rx_mode;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_cnt = 0;
			hold_cnt  = 0;
			mode_cnt  = 0;
			rx_mode   = 1;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (resp_due_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result item, pc_after %h", $time,
						rsp_ch.pc_after);
				end else begin
					e = resp_due_q.pop_front();
					check_field("pc_after", rsp_ch.pc_after, e.pc_after);
					check_field("instr_done", rsp_ch.instr_done, e.instr_done);
					check_field("reg_we", 32'(rsp_ch.reg_we), 32'(e.reg_we));
					check_field("reg_waddr", 32'(rsp_ch.reg_waddr), 32'(e.reg_waddr));
					check_field("reg_wdata", rsp_ch.reg_wdata, e.reg_wdata);
					check_field("mem_we", 32'(rsp_ch.mem_we), 32'(e.mem_we));
					check_field("mem_addr", rsp_ch.mem_addr, e.mem_addr);
					check_field("mem_wdata", rsp_ch.mem_wdata, e.mem_wdata);
					check_field("redirect", 32'(rsp_ch.redirect), 32'(e.redirect));
				end
				n_results++;
				// long hold-off so the core backs up into its input
				if (n_results == HOLD_AT)
					hold_cnt = HOLD_LEN;
			end
			mode_cnt++;
			if (mode_cnt % 256 == 0)
				rx_mode = $urandom_range(0, 2);
			if (hold_cnt != 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_cnt != 0) begin
				stall_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
				stall_cnt = pick_len() - 1;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	// watchdog: cycles without any handshake, includes the memory clearing pass
	always @(posedge clk) begin : wdog
		int unsigned idle_cnt;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cnt);
				$display("tb: failure");
				$finish;
			end
		end else
			idle_cnt = 0;
	end

	initial begin : main
		bit [31:0]   ins;
		int unsigned sel;
		bit          paused;
		arst_n       = 1'b0;
		pc_m         = 32'd0;
		errors       = 0;
		n_items      = 0;
		n_results    = 0;
		tx_mode      = 0;
		hold_tx      = 1'b0;
		paused       = 1'b0;

		// directed: unused func, zero word at reset, field extremes, every operation
		add_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(FUNC_EXEC, 32'd0, 32'd0);	// all-zero word: unknown funct, writes r0
		add_item(FUNC_DMEM_WR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(FUNC_DMEM_WR, 32'd0, 32'h8000_0001);
		run_at(enc_i(OPC_LW, 5'd0, 5'd1, 16'hFFFC), pc_m);	// negative offset
		run_at(enc_i(OPC_LW, 5'd0, 5'd2, 16'h0000), pc_m);
		run_at(enc_r(5'd1, 5'd2, 5'd3, FN_ADD), pc_m);
		run_at(enc_r(5'd2, 5'd1, 5'd4, FN_SUB), pc_m);
		run_at(enc_r(5'd1, 5'd2, 5'd5, FN_AND), pc_m);
		run_at(enc_r(5'd1, 5'd2, 5'd6, FN_OR), pc_m);
		run_at(enc_r(5'd2, 5'd1, 5'd7, FN_SLT), pc_m);	// gives 1, signed or unsigned
		run_at(enc_r(5'd1, 5'd2, 5'd3, 6'h3F), pc_m);	// unknown funct clears r3
		run_at(enc_r(5'd1, 5'd1, 5'd0, FN_ADD), pc_m);	// write to r0
		run_at(enc_i(OPC_SW, 5'd2, 5'd1, 16'h0004), pc_m);
		run_at(enc_i(OPC_BEQ, 5'd1, 5'd1, 16'h8000), pc_m);	// taken, wraps pc high
		run_at(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF), pc_m);	// not taken
		run_at({OPC_J, 26'h3FF_FFFF}, pc_m);
		run_at(32'hFFFF_FFFF, pc_m);	// unknown opcode

		// random: mostly instruction store + execute at the current pc
		hold_tx = 1'b1;
		while (n_items < N_ITEMS) begin
			if (n_items >= PAUSE_AT && !paused) begin
				hold_tx = 1'b1;
				paused  = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 3)
				add_item(FUNC_UNUSED, $urandom(), $urandom());
			else if (sel < 6)
				add_item(FUNC_DMEM_WR, $urandom(), $urandom());
			else if (sel < 8)
				add_item(FUNC_IMEM_WR, $urandom(), $urandom());
			else if (sel < 14)
				add_item(FUNC_EXEC, $urandom(), $urandom());	// whatever is stored there
			else begin
				ins = rand_instr();
				// give a load something nonzero to fetch
				if (ins[31:26] == OPC_LW && $urandom_range(0, 1) != 0)
					add_item(FUNC_DMEM_WR, rd_reg(ins[25:21]) + sext16(ins[15:0]),
						$urandom());
				run_at(ins, (pc_m & IMEM_IDX_MASK) | ($urandom() & ~IMEM_IDX_MASK));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pend_q.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (resp_due_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && resp_due_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
